FILE: rtl/kpc_pkg.sv
// ============================================================================
// kpc_pkg
// Shared types and constants for the key prefix compressor.
// ============================================================================
package kpc_pkg;

    // Key geometry
    localparam int MAX_KEY_LEN  = 32;
    localparam int PREFIX_CAP   = 255;
    localparam int STORE_DEPTH  = 64;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);

    // Field widths
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 8;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PREFIX   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_SLACK = 8'd1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] MIN_PREFIX_RST   = 8'd4;
    localparam logic [BYTE_W-1:0] PREFIX_SLACK_RST = 8'd10;

    // Result kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_SUFFIX = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take the input transaction
        logic step;      // compare the held byte and write it to the key store
        logic load_hdr;  // load the header result into the output register
        logic load_sfx;  // load one suffix byte into the output register
        logic finish;    // close the key and prepare for the next one
    } kpc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;      // held byte ends its key
        logic seed;      // held key is a seed
        logic hdr_only;  // chosen prefix covers the whole key
        logic sfx_last;  // current suffix byte is the final one
        logic out_free;  // output register can take a new result
    } kpc_status_t;

endpackage

FILE: rtl/kpc_ram.sv
// ============================================================================
// kpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module kpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/kpc_datapath.sv
// ============================================================================
// kpc_datapath
// Key store, match counting, prefix choice and the output register.
// ============================================================================
module kpc_datapath
    import kpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  kpc_cmd_t              cmd,
    output kpc_status_t           status,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data
);

    localparam logic [STORE_AW-1:0] MAX_LEN_V   = STORE_AW'(MAX_KEY_LEN);
    localparam logic [BYTE_W-1:0]   CAP_V       = BYTE_W'(PREFIX_CAP);

    // Held input transaction
    logic [BYTE_W-1:0]   byte_reg;
    logic [BYTE_W-1:0]   sp_reg;
    logic                last_reg;
    logic                seed_reg;

    // Key state
    logic [STORE_AW-1:0] pos_reg, pos_next;
    logic [STORE_AW-1:0] prev_len_reg, prev_len_next;
    logic [BYTE_W-1:0]   match_reg, match_next;
    logic                still_reg, still_next;
    logic [BYTE_W-1:0]   base_pfx_reg, base_pfx_next;
    logic                ovf_reg, ovf_next;
    logic [BYTE_W-1:0]   pfx_reg;
    logic [STORE_AW-1:0] ptr_reg, ptr_next;

    // Configuration
    logic [BYTE_W-1:0]   min_prefix_reg;
    logic [BYTE_W-1:0]   slack_reg;

    // Output register
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                m_last_reg;
    logic                m_user_reg;

    logic [BYTE_W-1:0]   rd_data;
    logic [STORE_AW-1:0] rd_addr;
    logic                in_range;
    logic                store_we;
    logic [BYTE_W-1:0]   pfx_comb;
    logic [BYTE_W:0]     slack_top;
    logic                out_free;

    assign in_range = (pos_reg < MAX_LEN_V);
    assign store_we = cmd.step && in_range;
    assign rd_addr  = cmd.capture ? pos_reg : ptr_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Key store: the previous key, overwritten in place by the current one.
    kpc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (store_we),
        .wr_addr (pos_reg),
        .wr_data (byte_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Prefix choice: drop short matches, reuse the previous prefix in its window.
    assign slack_top = {1'b0, base_pfx_reg} + {1'b0, slack_reg};

    always_comb
    begin
        if (match_reg < min_prefix_reg)
        begin
            pfx_comb = '0;
        end
        else if ((base_pfx_reg != '0) && (match_reg > base_pfx_reg)
                 && ({1'b0, match_reg} < slack_top))
        begin
            pfx_comb = base_pfx_reg;
        end
        else
        begin
            pfx_comb = match_reg;
        end
    end

    // Next-state logic of the key state.
    always_comb
    begin
        pos_next      = pos_reg;
        prev_len_next = prev_len_reg;
        match_next    = match_reg;
        still_next    = still_reg;
        base_pfx_next = base_pfx_reg;
        ovf_next      = ovf_reg;
        ptr_next      = ptr_reg;
        if (cmd.step)
        begin
            if (in_range)
            begin
                if (still_reg)
                begin
                    if ((pos_reg < prev_len_reg) && (match_reg < CAP_V)
                        && (rd_data == byte_reg))
                    begin
                        match_next = match_reg + 1'b1;
                    end
                    else
                    begin
                        still_next = 1'b0;
                    end
                end
                pos_next = pos_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.load_hdr)
        begin
            base_pfx_next = pfx_comb;
            ptr_next      = pfx_comb[STORE_AW-1:0];
        end
        if (cmd.load_sfx)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            if (seed_reg)
            begin
                base_pfx_next = sp_reg;
            end
            prev_len_next = pos_reg;
            pos_next      = '0;
            match_next    = '0;
            still_next    = 1'b1;
            ovf_next      = 1'b0;
        end
    end

    // Key state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            prev_len_reg <= '0;
            match_reg    <= '0;
            still_reg    <= 1'b1;
            base_pfx_reg <= '0;
            ovf_reg      <= 1'b0;
            ptr_reg      <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            prev_len_reg <= prev_len_next;
            match_reg    <= match_next;
            still_reg    <= still_next;
            base_pfx_reg <= base_pfx_next;
            ovf_reg      <= ovf_next;
            ptr_reg      <= ptr_next;
        end
    end

    // Held input transaction and chosen prefix (payload, no reset).
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= s_tdata[BYTE_W-1:0];
            sp_reg   <= s_tdata[2*BYTE_W-1:BYTE_W];
            last_reg <= s_tlast;
            seed_reg <= s_tuser;
        end
        if (cmd.load_hdr)
        begin
            pfx_reg <= pfx_comb;
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_prefix_reg <= MIN_PREFIX_RST;
            slack_reg      <= PREFIX_SLACK_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_MIN_PREFIX)
            begin
                min_prefix_reg <= cfg_data;
            end
            if (cfg_index == CFG_PREFIX_SLACK)
            begin
                slack_reg <= cfg_data;
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.load_hdr || cmd.load_sfx)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload: tdata = {pad, truncated, suffix_byte, prefix_len}.
    always_ff @(posedge clk)
    begin
        if (cmd.load_hdr)
        begin
            m_data_reg <= {7'b0, ovf_reg, 8'b0, pfx_comb};
            m_last_reg <= status.hdr_only;
            m_user_reg <= KIND_HEADER;
        end
        else if (cmd.load_sfx)
        begin
            m_data_reg <= {7'b0, 1'b0, rd_data, pfx_reg};
            m_last_reg <= status.sfx_last;
            m_user_reg <= KIND_SUFFIX;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // Status toward the controller.
    assign status.last     = last_reg;
    assign status.seed     = seed_reg;
    assign status.hdr_only = ({1'b0, pfx_comb} >= {3'b0, pos_reg});
    assign status.sfx_last = ((ptr_reg + 1'b1) == pos_reg);
    assign status.out_free = out_free;

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_hdr || cmd.load_sfx) |-> out_free)
        else $error("output register overwritten");

    // The stored key length never passes the buffer limit.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg <= MAX_LEN_V) && (prev_len_reg <= MAX_LEN_V))
        else $error("key length beyond limit");

    // The match count never exceeds the bytes stored so far.
    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        match_reg <= {3'b0, pos_reg})
        else $error("match count exceeds key length");

    // A suffix byte is read only below the key length.
    a_sfx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sfx |-> (ptr_reg < pos_reg))
        else $error("suffix read past key end");

endmodule

FILE: rtl/kpc_ctrl.sv
// ============================================================================
// kpc_ctrl
// Controller state machine sequencing key bytes, header and suffix output.
// ============================================================================
module kpc_ctrl
    import kpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  kpc_status_t status,
    output kpc_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_HDR  = 3'd2;
    localparam logic [2:0] ST_SRD  = 3'd3;
    localparam logic [2:0] ST_SOUT = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.step = 1'b1;
                if (!status.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.seed)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (status.out_free)
                begin
                    cmd.load_hdr = 1'b1;
                    state_next   = status.hdr_only ? ST_FIN : ST_SRD;
                end
            end
            ST_SRD:
            begin
                state_next = ST_SOUT;
            end
            ST_SOUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_sfx = 1'b1;
                    state_next   = status.sfx_last ? ST_FIN : ST_SRD;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Every accepted byte is compared in the following cycle.
    a_cmp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CMP))
        else $error("accepted byte not compared");

    // A suffix read always precedes its output load.
    a_read_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SOUT) && !$past(state_reg == ST_SOUT)
        |-> $past(state_reg == ST_SRD))
        else $error("suffix load without read");

    // Key close happens only after a completed key.
    a_fin_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_FIN) |-> ($past(state_reg == ST_CMP)
        || $past(state_reg == ST_HDR) || $past(state_reg == ST_SOUT)))
        else $error("unexpected key close");

endmodule

FILE: rtl/key_prefix_compressor.sv
// ============================================================================
// key_prefix_compressor
// Front coder for runs of sorted keys that arrive one byte per transaction.
// ============================================================================
// Each key byte is accepted while the byte at the same position of the
// previous key is read from the key store, and is then compared and written
// over it (the key store has one write and one registered read port).
// Bytes past the buffer length are dropped but still go through these steps.
// On the last byte of a non-seed key the block loads the header result, then
// for each suffix byte reads the store and loads the output, each load waiting
// for a free output register, and then closes the key; a seed key closes with
// no result. The last result of a key may still wait in the output register
// while the next key's bytes are accepted.
// ============================================================================
module key_prefix_compressor
    import kpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] key_byte, [15:8] seed_prefix
    input  logic                  s_tlast,   // end_of_key
    input  logic                  s_tuser,   // seed
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] prefix_len, [15:8] suffix_byte,
                                             // [16] truncated, [23:17] zero
    output logic                  m_tlast,   // final_res
    output logic                  m_tuser,   // kind
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data
);

    kpc_cmd_t    cmd;
    kpc_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    kpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kpc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the key prefix compressor.
// ============================================================================
// Keys are streamed byte by byte into the slave side. A scoreboard class
// front-codes the same keys in parallel and queues the header and suffix
// transactions the block should emit; every master-side transaction is popped
// and compared against it. Runs go through several register settings, with
// random gaps on the input and random back-pressure on the output.
// ============================================================================
module tb_top;
    import kpc_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_BYTES   = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd200;

    // One front-coded output transaction
    typedef struct packed {
        logic       kind;
        logic [7:0] prefix_len;
        logic [7:0] suffix_byte;
        logic       truncated;
        logic       final_res;
    } front_code_t;

    typedef logic [7:0] key_bytes_t[$];

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the front coder and the queue of codes due.
    // ------------------------------------------------------------------------
    class kpc_scoreboard_t;
        logic [7:0]  stored_key [STORE_DEPTH];
        int          prev_len;
        int          cur_len;
        int          match_cnt;
        bit          matching;
        logic [7:0]  base_pfx;
        bit          overflow;
        logic [7:0]  min_prefix;
        logic [7:0]  prefix_slack;
        front_code_t codes_due[$];
        int          errors;

        function new();
            prev_len     = 0;
            cur_len      = 0;
            match_cnt    = 0;
            matching     = 1'b1;
            base_pfx     = 8'd0;
            overflow     = 1'b0;
            min_prefix   = MIN_PREFIX_RST;
            prefix_slack = PREFIX_SLACK_RST;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_MIN_PREFIX:   min_prefix = val;
                CFG_PREFIX_SLACK: prefix_slack = val;
                default:          ;
            endcase
        endfunction

        // Short matches are dropped; a match just above the previous prefix
        // falls back to that prefix.
        function int pick_prefix_len(int m);
            int p;
            p = int'(base_pfx);
            if (m < int'(min_prefix))
                return 0;
            if (p != 0 && m > p && m < p + int'(prefix_slack))
                return p;
            return m;
        endfunction

        // Note one accepted key byte; on the last byte queue the key's codes.
        function void take_key_byte(logic [7:0] kb, logic last, logic seed_flag,
                                    logic [7:0] spfx);
            int          pos;
            int          pfx;
            int          i;
            front_code_t c;
            pos = cur_len;
            if (pos < MAX_KEY_LEN)
            begin
                if (matching)
                begin
                    if (pos < prev_len && match_cnt < PREFIX_CAP
                        && stored_key[pos] == kb)
                        match_cnt++;
                    else
                        matching = 1'b0;
                end
                stored_key[pos] = kb;
                cur_len = pos + 1;
            end
            else
            begin
                overflow = 1'b1;
            end
            if (!last)
                return;
            if (seed_flag)
            begin
                base_pfx = spfx;
            end
            else
            begin
                pfx = pick_prefix_len(match_cnt);
                c = '{KIND_HEADER, 8'(pfx), 8'd0, overflow, pfx >= cur_len};
                codes_due.push_back(c);
                for (i = pfx; i < cur_len; i++)
                begin
                    c = '{KIND_SUFFIX, 8'(pfx), stored_key[i], 1'b0, (i + 1) == cur_len};
                    codes_due.push_back(c);
                end
                base_pfx = 8'(pfx);
            end
            prev_len  = cur_len;
            cur_len   = 0;
            match_cnt = 0;
            matching  = 1'b1;
            overflow  = 1'b0;
        endfunction

        function void check_code(front_code_t got);
            front_code_t exp;
            if (codes_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected code kind=%0d prefix_len=%0d suffix=%02h",
                         $time, got.kind, got.prefix_len, got.suffix_byte,
                         " trunc=%0d last=%0d", got.truncated, got.final_res);
                return;
            end
            exp = codes_due.pop_front();
            if (got !== exp)
            begin
                errors++;
                $display("%0t: code mismatch: expected kind=%0d prefix_len=%0d",
                         $time, exp.kind, exp.prefix_len,
                         " suffix=%02h trunc=%0d last=%0d",
                         exp.suffix_byte, exp.truncated, exp.final_res);
                $display("%0t:                actual   kind=%0d prefix_len=%0d",
                         $time, got.kind, got.prefix_len,
                         " suffix=%02h trunc=%0d last=%0d",
                         got.suffix_byte, got.truncated, got.final_res);
            end
        endfunction

        function void flag_leftovers();
            if (codes_due.size() != 0)
            begin
                errors += codes_due.size();
                $display("%0t: %0d expected codes never arrived, next kind=%0d",
                         $time, codes_due.size(), codes_due[0].kind,
                         " prefix_len=%0d", codes_due[0].prefix_len);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    kpc_scoreboard_t sb = new();
    key_bytes_t      run_key;
    bit              quiet;
    bit              tx_bursty;
    int              cycle_count;

    key_prefix_compressor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t: run limit reached", $time);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Output side: back-pressure in random bursts, changed at the falling edge
    initial
    begin
        int stall_left;
        int window;
        bit stalls_on;
        stall_left = 0;
        window     = 0;
        stalls_on  = 1'b1;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (window == 0)
            begin
                window    = $urandom_range(20, 120);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            window--;
            if (quiet || !stalls_on)
            begin
                stall_left = 0;
                m_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Output monitor: every accepted transaction goes to the scoreboard
    always @(posedge clk)
    begin
        front_code_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind        = m_tuser;
            got.prefix_len  = m_tdata[7:0];
            got.suffix_byte = m_tdata[15:8];
            got.truncated   = m_tdata[16];
            got.final_res   = m_tlast;
            sb.check_code(got);
        end
    end

    // Send one key byte, after an optional idle burst
    task automatic send_byte(input logic [7:0] kb, input logic last,
                             input logic seed_flag, input logic [7:0] spfx);
        int gap;
        if (!quiet && tx_bursty && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {spfx, kb};
        s_tlast  <= last;
        s_tuser  <= seed_flag;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.take_key_byte(kb, last, seed_flag, spfx);
    endtask

    // Send a whole key. Seed flag and seed prefix carry noise on inner bytes.
    task automatic send_key(input key_bytes_t k, input bit as_seed, input logic [7:0] spfx);
        int  i;
        bit  last;
        tx_bursty = ($urandom_range(0, 3) != 0);
        for (i = 0; i < k.size(); i++)
        begin
            last = (i == k.size() - 1);
            send_byte(k[i], last, last ? as_seed : 1'($urandom_range(0, 1)),
                      last ? spfx : 8'($urandom));
        end
        run_key = {};
        for (i = 0; i < k.size() && i < MAX_KEY_LEN; i++)
            run_key.push_back(k[i]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and let every queued code drain, then let the block settle
    task automatic drain_codes();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.codes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Byte source biased toward a few values so that keys share prefixes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'h41 + 8'($urandom_range(0, 2));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic key_bytes_t fresh_key();
        key_bytes_t k;
        int         len;
        int         i;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                           : $urandom_range(1, 10);
        for (i = 0; i < len; i++)
            k.push_back(pick_byte());
        return k;
    endfunction

    // Next key of a run: a chosen slice of the previous key plus new bytes.
    // Some slices are aimed just above the previous prefix, at the reuse window.
    function automatic key_bytes_t related_key();
        key_bytes_t k;
        int         keep;
        int         extra;
        int         sel;
        int         i;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            keep = int'(sb.base_pfx) + $urandom_range(1, 12);
        else if (sel < 8)
            keep = $urandom_range(0, run_key.size());
        else
            keep = $urandom_range(0, 3);
        if (keep > run_key.size())
            keep = run_key.size();
        for (i = 0; i < keep; i++)
            k.push_back(run_key[i]);
        extra = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 38)
                                              : $urandom_range(0, 6);
        if (keep + extra == 0)
            extra = 1;
        for (i = 0; i < extra; i++)
            k.push_back(pick_byte());
        return k;
    endfunction

    // Runs of keys: mostly a seed followed by related keys, some runs without
    // a seed and an occasional seed in the middle. Stops once the byte budget
    // is spent.
    task automatic run_keys(input int budget);
        key_bytes_t k;
        int         sent;
        int         nkeys;
        logic [7:0] spfx;
        sent = 0;
        while (sent < budget)
        begin
            k = fresh_key();
            spfx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
            send_key(k, $urandom_range(0, 5) != 0, spfx);
            sent += k.size();
            nkeys = $urandom_range(2, 7);
            while (nkeys > 0 && sent < budget)
            begin
                k = related_key();
                spfx = 8'($urandom_range(0, 12));
                send_key(k, $urandom_range(0, 9) == 0, spfx);
                sent += k.size();
                nkeys--;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        key_bytes_t k;
        int         i;
        int         ph;
        logic [7:0] min_set [NUM_PHASES];
        logic [7:0] slack_set [NUM_PHASES];

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        tx_bursty = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed keys at the reset settings (min_prefix 4, slack 10)
        send_key({8'h00, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h44}, 1'b1, 8'h00);
        // Shared prefix of five bytes, two suffix bytes
        send_key({8'h00, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h45, 8'h46}, 1'b0, 8'h00);
        // Identical key: the previous prefix of five is reused, two suffix bytes
        send_key({8'h00, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h45, 8'h46}, 1'b0, 8'h00);
        // Match below min_prefix is not compressed
        send_key({8'h00, 8'hFF}, 1'b0, 8'h00);
        send_key({8'h00, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48},
                 1'b1, 8'h03);
        // Match of seven just above the seed prefix of three: three is reused
        send_key({8'h00, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h58}, 1'b0, 8'h00);
        // Long key: cut to the buffer length and flagged
        k = {8'h00, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h58};
        for (i = 0; i < 26; i++)
            k.push_back(i[0] ? 8'hAA : 8'h55);
        send_key(k, 1'b0, 8'h00);
        // Overflowing seed with the largest seed prefix
        k = {};
        for (i = 0; i < MAX_KEY_LEN + 1; i++)
            k.push_back(8'(i * 9));
        send_key(k, 1'b1, 8'hFF);
        // Single-byte key that differs at once
        send_key({8'hFF}, 1'b0, 8'h00);

        // Random phases, each behind a register change
        min_set[0] = 8'd0;   slack_set[0] = 8'd0;
        min_set[1] = 8'd255; slack_set[1] = 8'd255;
        min_set[2] = 8'($urandom_range(1, 6));  slack_set[2] = 8'd255;
        min_set[3] = 8'd255; slack_set[3] = 8'd0;
        min_set[4] = 8'($urandom_range(0, 8));  slack_set[4] = 8'($urandom);
        min_set[5] = MIN_PREFIX_RST;            slack_set[5] = PREFIX_SLACK_RST;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_codes();
            write_reg(CFG_MIN_PREFIX, min_set[ph]);
            write_reg(CFG_PREFIX_SLACK, slack_set[ph]);
            if (ph == 3 || ph == 5)
                write_reg(CFG_UNMAPPED, 8'($urandom));
            quiet = (ph == NUM_PHASES - 1);
            run_keys(PHASE_BYTES);
        end

        // Wind down
        drain_codes();
        sb.flag_leftovers();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/kpc_pkg.sv
rtl/kpc_ram.sv
rtl/kpc_datapath.sv
rtl/kpc_ctrl.sv
rtl/key_prefix_compressor.sv
bench/tb_top.sv
